FILE: hdl/ebbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbd_pkg
// Shared types and constants for the built-in expansion-bus device core.
// ----------------------------------------------------------------------------
package ebbd_pkg;

    // Default sizes
    localparam int COMMAND_LENGTH = 7;
    localparam int STATUS_DEPTH   = 16;

    // Register access codes
    typedef enum logic [2:0] {
        OP_SELECT_WR   = 3'd0,
        OP_COMMAND_WR  = 3'd1,
        OP_STATUS_RD   = 3'd2,
        OP_POLL_WR     = 3'd3,
        OP_POLL_RD     = 3'd4,
        OP_DATA_RD     = 3'd5,
        OP_DATA_WR     = 3'd6,
        OP_RESERVED_RD = 3'd7
    } opcode_t;

    // Device constants
    localparam logic [3:0] BUILTIN_SELECT  = 4'hF;
    localparam logic [7:0] CMD_STATUS_REQ  = 8'h83;
    localparam logic [7:0] STATUS_FILL     = 8'h01;
    localparam logic [7:0] OTHER_POLL      = 8'h30;
    localparam logic [7:0] POLL_RESET      = 8'h0F;
    localparam logic [7:0] LOW_NIBBLE      = 8'h0F;
    localparam int         REPLY_LENGTH    = 12;

    // Poll register bit positions
    localparam int MASK_STATUS_BIT = 0;
    localparam int MASK_DATA_BIT   = 1;
    localparam int FLAG_STATUS_BIT = 4;
    localparam int FLAG_DATA_BIT   = 5;
    // Select high nibble bit that masks poll reads
    localparam int SEL_MASK_BIT    = 3;

    // Input transfer payload
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_value;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [7:0] read_value;
        logic       interrupt_pulse;
    } out_item_t;

endpackage

FILE: hdl/ebbd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbd_in_stage
// Input register: captures one access per cycle unless stalled, hands it on.
// ----------------------------------------------------------------------------
module ebbd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ebbd_pkg::in_item_t s_payload,
    output logic              item_valid,
    input  logic              item_ready,
    output ebbd_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    ebbd_pkg::in_item_t item_reg;

    // Accept whenever the held access leaves or nothing is held
    assign s_ready    = !valid_reg || item_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every accepted transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/ebbd_device.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbd_device
// Device state, access decode and result register.
// ----------------------------------------------------------------------------
module ebbd_device #(
    parameter int COMMAND_LENGTH = ebbd_pkg::COMMAND_LENGTH,
    parameter int STATUS_DEPTH   = ebbd_pkg::STATUS_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  ebbd_pkg::in_item_t  item,
    output logic                m_valid,
    input  logic                m_ready,
    output ebbd_pkg::out_item_t m_payload
);

    localparam int CW  = $clog2(COMMAND_LENGTH + 1);
    localparam int SCW = $clog2(STATUS_DEPTH + 1);
    localparam int HW  = $clog2(STATUS_DEPTH);
    localparam logic [CW-1:0]  CMD_LAST  = CW'(COMMAND_LENGTH - 1);
    localparam logic [HW-1:0]  HEAD_LAST = HW'(STATUS_DEPTH - 1);
    localparam logic [SCW-1:0] REPLY_CNT = SCW'(ebbd_pkg::REPLY_LENGTH);

    logic [3:0]     sel_reg, sel_next;
    logic [3:0]     sel_high_reg, sel_high_next;
    logic [7:0]     poll_reg, poll_next;
    logic [7:0]     first_reg, first_next;
    logic [CW-1:0]  cmd_count_reg, cmd_count_next;
    logic [SCW-1:0] st_count_reg, st_count_next;
    logic [HW-1:0]  head_reg, head_next;
    logic           out_valid_reg, out_valid_next;
    ebbd_pkg::out_item_t out_reg, out_next;

    logic              advance;
    logic              builtin;
    logic [7:0]        first_byte;
    logic [7:0]        poll_rd;
    ebbd_pkg::opcode_t op;

    assign item_ready = !out_valid_reg || m_ready;
    assign advance    = item_valid && item_ready;
    assign builtin    = (sel_reg == ebbd_pkg::BUILTIN_SELECT);
    assign op         = ebbd_pkg::opcode_t'(item.opcode);
    assign first_byte = (cmd_count_reg == '0) ? item.write_value : first_reg;

    // Decode one access and compute the next state and result
    always_comb begin
        sel_next       = sel_reg;
        sel_high_next  = sel_high_reg;
        poll_next      = poll_reg;
        first_next     = first_reg;
        cmd_count_next = cmd_count_reg;
        st_count_next  = st_count_reg;
        head_next      = head_reg;
        out_next       = out_reg;
        poll_rd        = builtin ? poll_reg : ebbd_pkg::OTHER_POLL;
        if (sel_high_reg[ebbd_pkg::SEL_MASK_BIT]) begin
            poll_rd = poll_rd & ebbd_pkg::LOW_NIBBLE;
        end
        if (advance) begin
            out_next.read_value      = 8'h00;
            out_next.interrupt_pulse = 1'b0;
            unique case (op)
                ebbd_pkg::OP_SELECT_WR: begin
                    sel_next      = item.write_value[3:0];
                    sel_high_next = item.write_value[7:4];
                end
                ebbd_pkg::OP_COMMAND_WR: begin
                    if (builtin) begin
                        if (cmd_count_reg == CMD_LAST) begin
                            // Full buffer: run the command
                            cmd_count_next = '0;
                            if (first_byte == ebbd_pkg::CMD_STATUS_REQ) begin
                                head_next     = '0;
                                st_count_next = REPLY_CNT;
                                poll_next[ebbd_pkg::FLAG_STATUS_BIT] = 1'b1;
                            end
                            out_next.interrupt_pulse =
                                (poll_next[ebbd_pkg::FLAG_STATUS_BIT]
                                 && poll_next[ebbd_pkg::MASK_STATUS_BIT])
                                || (poll_next[ebbd_pkg::FLAG_DATA_BIT]
                                 && poll_next[ebbd_pkg::MASK_DATA_BIT]);
                        end else begin
                            cmd_count_next = cmd_count_reg + CW'(1);
                            first_next     = first_byte;
                        end
                    end
                end
                ebbd_pkg::OP_STATUS_RD: begin
                    if (builtin && st_count_reg != '0) begin
                        // Queue holds the request byte at its start, fill after
                        out_next.read_value = (head_reg == '0) ? ebbd_pkg::CMD_STATUS_REQ
                                                               : ebbd_pkg::STATUS_FILL;
                        head_next     = (head_reg == HEAD_LAST) ? '0 : head_reg + HW'(1);
                        st_count_next = st_count_reg - SCW'(1);
                        if (st_count_reg == SCW'(1)) begin
                            poll_next[ebbd_pkg::FLAG_STATUS_BIT] = 1'b0;
                        end
                    end
                end
                ebbd_pkg::OP_POLL_WR: begin
                    if (builtin) begin
                        poll_next[3:0] = item.write_value[3:0];
                    end
                end
                ebbd_pkg::OP_POLL_RD: begin
                    out_next.read_value = poll_rd;
                end
                ebbd_pkg::OP_DATA_RD,
                ebbd_pkg::OP_DATA_WR,
                ebbd_pkg::OP_RESERVED_RD: begin
                end
                default: begin
                end
            endcase
        end
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_ready);
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg       <= 4'h0;
            sel_high_reg  <= 4'h0;
            poll_reg      <= ebbd_pkg::POLL_RESET;
            cmd_count_reg <= '0;
            st_count_reg  <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sel_reg       <= sel_next;
            sel_high_reg  <= sel_high_next;
            poll_reg      <= poll_next;
            cmd_count_reg <= cmd_count_next;
            st_count_reg  <= st_count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        out_reg   <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

FILE: hdl/expansion_bus_builtin_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expansion_bus_builtin_device_core
// Built-in device at bus select 15: command buffer, status queue, poll
// register and fast-interrupt pulse, one register access per transfer.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   opcode[2:0], write_value[7:0]
//   m_       out        m_valid / m_ready   read_value[7:0], interrupt_pulse
//
// One access enters per cycle while results are taken; each access passes through the
// input register and is presented from the result register.
// Synchronous active-low reset clears select, counts and pointer, and loads
// poll with 0x0F.
// A stalled result holds the result register; an empty input register still
// takes one more access, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module expansion_bus_builtin_device_core #(
    parameter int COMMAND_LENGTH = ebbd_pkg::COMMAND_LENGTH,
    parameter int STATUS_DEPTH   = ebbd_pkg::STATUS_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ebbd_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ebbd_pkg::out_item_t m_payload
);

    logic               item_valid;
    logic               item_ready;
    ebbd_pkg::in_item_t item;

    // Register the incoming access
    ebbd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Apply the access to device state and register the result
    ebbd_device #(
        .COMMAND_LENGTH (COMMAND_LENGTH),
        .STATUS_DEPTH   (STATUS_DEPTH)
    ) u_device (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

FILE: sim/tb_expansion_bus_builtin_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expansion_bus_builtin_device_core
// Self-checking bench for the built-in expansion-bus device core. A short
// directed sequence covers the other-select paths, poll masking and both
// interrupt outcomes. A long random run follows: well-formed select and
// command sequences, status drains and poll accesses, mixed with broken
// sequences and noise. Both channels idle at random. Every result is checked
// against a cycle-free model of the device that is kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_expansion_bus_builtin_device_core;
    import ebbd_pkg::*;

    localparam int ACCESS_TARGET = 1600;
    localparam int DRAIN_CYCLES  = 8;

    // ------------------------------------------------------------------------
    // Device model and reply checker
    // ------------------------------------------------------------------------
    class bus_device_scoreboard;
        logic [3:0] dev_select;
        logic [3:0] select_high;
        logic [7:0] poll_reg;
        logic [7:0] cmd_bytes [COMMAND_LENGTH];
        int         cmd_fill;
        logic [7:0] status_ring [STATUS_DEPTH];
        int         status_left;
        int         status_rd_ptr;
        out_item_t  pending_replies [$];
        int         mismatches;
        int         replies_checked;
        int         accesses_seen;
        int         irq_raised;
        int         reloads;
        int         status_popped;
        int         ops_seen [8];

        function new();
            dev_select    = '0;
            select_high   = '0;
            poll_reg      = POLL_RESET;
            cmd_fill      = 0;
            status_left   = 0;
            status_rd_ptr = 0;
            mismatches    = 0;
            replies_checked = 0;
            accesses_seen = 0;
            irq_raised    = 0;
            reloads       = 0;
            status_popped = 0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
        endfunction

        // Run a full command; reload the status ring on a status request
        function logic execute_command();
            if (cmd_bytes[0] == CMD_STATUS_REQ) begin
                status_rd_ptr = 0;
                status_left   = REPLY_LENGTH;
                status_ring[0] = CMD_STATUS_REQ;
                for (int i = 1; i < REPLY_LENGTH; i++)
                    status_ring[i % STATUS_DEPTH] = STATUS_FILL;
                poll_reg[FLAG_STATUS_BIT] = 1'b1;
                reloads++;
            end
            return (poll_reg[FLAG_STATUS_BIT] && poll_reg[MASK_STATUS_BIT]) ||
                   (poll_reg[FLAG_DATA_BIT] && poll_reg[MASK_DATA_BIT]);
        endfunction

        // Pop one status byte; clear the pending flag when the ring empties
        function logic [7:0] pop_status_byte();
            logic [7:0] b;
            if (status_left == 0)
                return 8'h00;
            b = status_ring[status_rd_ptr];
            status_rd_ptr = (status_rd_ptr + 1) % STATUS_DEPTH;
            status_left--;
            status_popped++;
            if (status_left == 0)
                poll_reg[FLAG_STATUS_BIT] = 1'b0;
            return b;
        endfunction

        // Advance the model by one accepted access and queue its reply
        function void note_access(in_item_t acc);
            out_item_t  want;
            opcode_t    op;
            logic [7:0] v;
            logic       at_builtin;
            op = opcode_t'(acc.opcode);
            v  = acc.write_value;
            want = '0;
            at_builtin = (dev_select == BUILTIN_SELECT);
            accesses_seen++;
            ops_seen[acc.opcode]++;
            case (op)
                OP_SELECT_WR: begin
                    dev_select  = v[3:0];
                    select_high = v[7:4];
                end
                OP_COMMAND_WR: begin
                    if (at_builtin) begin
                        if (cmd_fill < COMMAND_LENGTH) begin
                            cmd_bytes[cmd_fill] = v;
                            cmd_fill++;
                        end
                        if (cmd_fill >= COMMAND_LENGTH) begin
                            want.interrupt_pulse = execute_command();
                            cmd_fill = 0;
                        end
                    end
                end
                OP_STATUS_RD: begin
                    if (at_builtin)
                        want.read_value = pop_status_byte();
                end
                OP_POLL_WR: begin
                    if (at_builtin)
                        poll_reg = {poll_reg[7:4], v[3:0]};
                end
                OP_POLL_RD: begin
                    want.read_value = at_builtin ? poll_reg : OTHER_POLL;
                    if (select_high[SEL_MASK_BIT])
                        want.read_value = want.read_value & LOW_NIBBLE;
                end
                default: ;
            endcase
            if (want.interrupt_pulse)
                irq_raised++;
            pending_replies.push_back(want);
        endfunction

        // Print one line per mismatch and count it
        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Compare a returned reply with the oldest one predicted
        task check_result(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected reply read_value=0x%02h irq=%0b",
                                          got.read_value, got.interrupt_pulse));
                return;
            end
            want = pending_replies.pop_front();
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("reply %0d read_value got 0x%02h want 0x%02h",
                                          replies_checked, got.read_value,
                                          want.read_value));
            if (got.interrupt_pulse !== want.interrupt_pulse)
                report_mismatch($sformatf("reply %0d interrupt_pulse got %0b want %0b",
                                          replies_checked, got.interrupt_pulse,
                                          want.interrupt_pulse));
            replies_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    bus_device_scoreboard sb;
    int sent_count;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    expansion_bus_builtin_device_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ------------------------------------------------------------------------
    // Access driver
    // ------------------------------------------------------------------------
    // Idle a random number of cycles, then hold the access until transfer.
    // Called at a rising edge; leaves s_valid high on return.
    task automatic send_access(input opcode_t op, input logic [7:0] value);
        int gap;
        // run a no-idle stretch in the last 60 of every 300 accesses
        gap = ((sent_count % 300) >= 240) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_payload.opcode    <= op;
        s_payload.write_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(s_payload);
        sent_count++;
    endtask

    // Send a command of the given length; later bytes are random
    task automatic send_command(input logic [7:0] first_byte, input int len);
        send_access(OP_COMMAND_WR, first_byte);
        for (int i = 1; i < len; i++)
            send_access(OP_COMMAND_WR, 8'($urandom_range(0, 255)));
    endtask

    // Select write that mostly lands on the built-in device
    task automatic send_select();
        logic [3:0] low;
        low = ($urandom_range(0, 9) < 8) ? BUILTIN_SELECT : 4'($urandom_range(0, 15));
        send_access(OP_SELECT_WR, {4'($urandom_range(0, 15)), low});
    endtask

    // ------------------------------------------------------------------------
    // Result sink
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            // hold off in random gaps, except for a no-stall stretch
            stall = ((sb.replies_checked % 300) < 60) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_payload);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("timeout with %0d replies outstanding", sb.pending_replies.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int len;
        sb = new();
        sent_count = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Other select: writes ignored, reads return zero or the idle poll
        send_access(OP_POLL_RD, 8'h00);
        send_access(OP_COMMAND_WR, 8'hFF);
        send_access(OP_STATUS_RD, 8'hFF);
        send_access(OP_POLL_WR, 8'h00);
        send_access(OP_DATA_WR, 8'hFF);
        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_RESERVED_RD, 8'hFF);
        // Select bit 7 masks the idle poll value
        send_access(OP_SELECT_WR, 8'h80);
        send_access(OP_POLL_RD, 8'h00);
        // Built-in with poll masking; empty status read, then a status request
        send_access(OP_SELECT_WR, 8'hFF);
        send_access(OP_STATUS_RD, 8'h00);
        send_command(CMD_STATUS_REQ, COMMAND_LENGTH);
        send_access(OP_POLL_RD, 8'h00);
        // Unmasked poll shows the pending flag; clear masks, no interrupt
        send_access(OP_SELECT_WR, 8'h0F);
        send_access(OP_POLL_RD, 8'hFF);
        send_access(OP_POLL_WR, 8'hF0);
        send_command(8'h00, COMMAND_LENGTH);

        // Random sequences, mostly well formed
        while (sent_count < ACCESS_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_select();
            end else if (pick < 40) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, COMMAND_LENGTH)
                                                  : COMMAND_LENGTH;
                send_command(($urandom_range(0, 1) == 0) ? CMD_STATUS_REQ
                                                         : 8'($urandom_range(0, 255)),
                             len);
            end else if (pick < 65) begin
                len = $urandom_range(1, REPLY_LENGTH + 1);
                repeat (len) send_access(OP_STATUS_RD, 8'($urandom_range(0, 255)));
            end else if (pick < 75) begin
                send_access(OP_POLL_WR, 8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                send_access(OP_POLL_RD, 8'($urandom_range(0, 255)));
            end else begin
                send_access(opcode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding replies, then allow for any stray ones
        while (sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending_replies.size() != 0)
            sb.report_mismatch($sformatf("%0d replies never returned",
                                         sb.pending_replies.size()));

        $display("covered %0d accesses (select %0d, command %0d, status %0d, poll %0d/%0d)",
                 sb.accesses_seen, sb.ops_seen[OP_SELECT_WR], sb.ops_seen[OP_COMMAND_WR],
                 sb.ops_seen[OP_STATUS_RD], sb.ops_seen[OP_POLL_WR], sb.ops_seen[OP_POLL_RD]);
        $display("checked %0d replies: %0d interrupts, %0d status reloads, %0d bytes popped",
                 sb.replies_checked, sb.irq_raised, sb.reloads, sb.status_popped);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ebbd_pkg.sv
hdl/ebbd_in_stage.sv
hdl/ebbd_device.sv
hdl/expansion_bus_builtin_device_core.sv
sim/tb_expansion_bus_builtin_device_core.sv
